// ===== rtl/core/tccw_pkg.sv =====
// shared constants, types and codes of the text console cell writer
`timescale 1ns / 1ps

package tccw_pkg;

   // screen geometry
   localparam int ROWS   = 25;
   localparam int COLS   = 80;
   localparam int CELLS  = ROWS * COLS;
   localparam int CELL_W = $clog2(CELLS);

   // field widths
   localparam int MODE_W  = 3;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int OFF_W   = 11;
   localparam int MUL_W   = ROW_W + COL_W;
   localparam int CSR_W   = 32;
   localparam int PADDR_W = 3;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CURSOR = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DRAW   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   // special characters
   localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0a;
   localparam logic [CHAR_W-1:0] BACKSPACE_CHAR = 8'h08;
   localparam logic [CHAR_W-1:0] RETURN_CHAR    = 8'h0d;

   localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd2;

   // register index of text_color
   localparam logic REG_TEXT_COLOR = 1'b0;

   typedef logic [COLOR_W+CHAR_W-1:0] cell_type;

   typedef struct packed {
      logic              en;
      logic [CELL_W-1:0] addr;
      cell_type          data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [CELL_W-1:0] addr;
   } ram_rd_type;

endpackage

// ===== rtl/core/tccw_if.sv =====
// request and response channel interfaces of the text console cell writer
`timescale 1ns / 1ps

interface tccw_req_if;
   import tccw_pkg::*;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [CHAR_W-1:0]  char_code;
   logic [ROW_W-1:0]   target_row;
   logic [COL_W-1:0]   target_col;
   logic [COLOR_W-1:0] cell_color;

   modport source (output valid, mode, char_code, target_row, target_col, cell_color,
                   input ready);
   modport sink (input valid, mode, char_code, target_row, target_col, cell_color,
                 output ready);
endinterface

interface tccw_rsp_if;
   import tccw_pkg::*;
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  caret_row;
   logic [COL_W-1:0]  caret_col;
   logic [OFF_W-1:0]  cursor_offset;
   logic [CHAR_W-1:0] read_char;
   logic              bad_position;

   modport source (output valid, caret_row, caret_col, cursor_offset, read_char,
                   bad_position, input ready);
   modport sink (input valid, caret_row, caret_col, cursor_offset, read_char,
                 bad_position, output ready);
endinterface

// ===== rtl/core/text_console_cell_writer_unit.sv =====
// top level of the text console cell writer: sequencer, cursor, register port
`timescale 1ns / 1ps
// sequence: a request passes ST_EXEC and then ST_FINISH; read and backspace add ST_RD_WAIT
//   or ST_BSPACE between them; a scroll adds ST_SCRL_PRE and a ST_SCRL pass and a clear
//   a ST_CLEAR pass, each walking every cell through the single screen memory write port
// throughput: one request at a time; ready only while the sequencer is idle
// reset: synchronous; a clearing pass over all ROWS*COLS (2000) cells blanks the screen
//   in colour 2 before the first request is taken; register writes are taken meanwhile

module text_console_cell_writer_unit (
   input  logic                          clock,
   input  logic                          reset,
   tccw_req_if.sink                      req_chan,
   tccw_rsp_if.source                    rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tccw_pkg::PADDR_W-1:0]  paddr,
   input  logic [tccw_pkg::CSR_W-1:0]    pwdata,
   output logic [tccw_pkg::CSR_W-1:0]    prdata,
   output logic                          pready
);
   import tccw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BSPACE,
      ST_RD_WAIT,
      ST_SCRL_PRE,
      ST_SCRL,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [CELL_W-1:0]  cnt_ff, cnt_in;
   logic [COLOR_W-1:0] fill_color_ff, fill_color_in;
   logic               init_ff, init_in;
   logic [COLOR_W-1:0] text_color_ff, text_color_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;

   // latched request
   logic [MODE_W-1:0]  op_mode_ff, op_mode_in;
   logic [CHAR_W-1:0]  op_char_ff, op_char_in;
   logic [ROW_W-1:0]   op_row_ff, op_row_in;
   logic [COL_W-1:0]   op_col_ff, op_col_in;
   logic [COLOR_W-1:0] op_color_ff, op_color_in;
   logic               bad_ff, bad_in;
   logic [CHAR_W-1:0]  rdchar_ff, rdchar_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [OFF_W-1:0]   rsp_off_ff, rsp_off_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_bad_ff, rsp_bad_in;

   ram_wr_type         ram_wr;
   ram_rd_type         ram_rd;
   cell_type           ram_rd_data;

   // shared address unit: row * COLS + col
   logic               use_target;
   logic [ROW_W-1:0]   u_row;
   logic [COL_W-1:0]   u_col;
   logic [MUL_W-1:0]   u_out;
   logic [CELL_W-1:0]  u_addr;
   logic               target_ok;
   logic               slot_free;
   logic [CELL_W:0]    scrl_rd_next;

   tccw_screen_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   // register port: one register, decoded on the word index only
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TEXT_COLOR) ?
                   {{(CSR_W-COLOR_W){1'b0}}, text_color_ff} : '0;

   assign use_target = (state_ff == ST_EXEC) &&
                       ((op_mode_ff == MODE_DRAW) || (op_mode_ff == MODE_READ));
   assign u_row  = use_target ? op_row_ff : cur_row_ff;
   assign u_col  = use_target ? op_col_ff : cur_col_ff;
   assign u_out  = MUL_W'(u_row) * MUL_W'(COLS) + MUL_W'(u_col);
   assign u_addr = u_out[CELL_W-1:0];

   assign target_ok = (op_row_ff < ROW_W'(ROWS)) && (op_col_ff < COL_W'(COLS));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   // next source cell of the scroll copy, one row below the cell written next
   assign scrl_rd_next = {1'b0, cnt_ff} + (CELL_W+1)'(COLS + 1);

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.caret_row     = rsp_row_ff;
   assign rsp_chan.caret_col     = rsp_col_ff;
   assign rsp_chan.cursor_offset = rsp_off_ff;
   assign rsp_chan.read_char     = rsp_char_ff;
   assign rsp_chan.bad_position  = rsp_bad_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      fill_color_in = fill_color_ff;
      init_in       = init_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      op_mode_in    = op_mode_ff;
      op_char_in    = op_char_ff;
      op_row_in     = op_row_ff;
      op_col_in     = op_col_ff;
      op_color_in   = op_color_ff;
      bad_in        = bad_ff;
      rdchar_in     = rdchar_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_bad_in    = rsp_bad_ff;
      ram_wr        = '0;
      ram_rd        = '0;

      // register writes are taken in any state
      text_color_in = text_color_ff;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_TEXT_COLOR)) begin
         text_color_in = pwdata[COLOR_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_mode_in  = req_chan.mode;
               op_char_in  = req_chan.char_code;
               op_row_in   = req_chan.target_row;
               op_col_in   = req_chan.target_col;
               op_color_in = req_chan.cell_color;
               bad_in      = 1'b0;
               rdchar_in   = '0;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_FINISH;
            unique case (op_mode_ff)
               MODE_PUT: begin
                  priority if (op_char_ff == NEWLINE_CHAR) begin
                     cur_col_in = '0;
                     if (cur_row_ff == ROW_W'(ROWS - 1)) begin
                        state_in = ST_SCRL_PRE;
                     end else begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end
                  end else if (op_char_ff == BACKSPACE_CHAR) begin
                     // top-left cell: nothing to erase
                     if ((cur_row_ff != '0) || (cur_col_ff != '0)) begin
                        if (cur_col_ff == '0) begin
                           cur_row_in = cur_row_ff - 1'b1;
                           cur_col_in = COL_W'(COLS - 1);
                        end else begin
                           cur_col_in = cur_col_ff - 1'b1;
                        end
                        state_in = ST_BSPACE;
                     end
                  end else if (op_char_ff == RETURN_CHAR) begin
                     cur_col_in = '0;
                  end else begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = u_addr;
                     ram_wr.data = {text_color_ff, op_char_ff};
                     if (cur_col_ff == COL_W'(COLS - 1)) begin
                        cur_col_in = '0;
                        // past the last cell: scroll, cursor stays on the last row
                        if (cur_row_ff == ROW_W'(ROWS - 1)) begin
                           state_in = ST_SCRL_PRE;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end
               end
               MODE_CURSOR: begin
                  if (target_ok) begin
                     cur_row_in = op_row_ff;
                     cur_col_in = op_col_ff;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               MODE_DRAW: begin
                  if (target_ok) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = u_addr;
                     ram_wr.data = {op_color_ff, op_char_ff};
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               MODE_READ: begin
                  if (target_ok) begin
                     ram_rd.en   = 1'b1;
                     ram_rd.addr = u_addr;
                     state_in    = ST_RD_WAIT;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               MODE_CLEAR: begin
                  cur_row_in    = '0;
                  cur_col_in    = '0;
                  cnt_in        = '0;
                  fill_color_in = text_color_ff;
                  state_in      = ST_CLEAR;
               end
               default: begin
                  // unused modes only report the cursor
               end
            endcase
         end

         ST_BSPACE: begin
            // cursor already stepped back; blank the cell under it
            ram_wr.en   = 1'b1;
            ram_wr.addr = u_addr;
            ram_wr.data = {text_color_ff, BLANK_CHAR};
            state_in    = ST_FINISH;
         end

         ST_RD_WAIT: begin
            rdchar_in = ram_rd_data[CHAR_W-1:0];
            state_in  = ST_FINISH;
         end

         ST_SCRL_PRE: begin
            // prime the read of the first cell of the second row
            ram_rd.en   = 1'b1;
            ram_rd.addr = CELL_W'(COLS);
            cnt_in      = '0;
            state_in    = ST_SCRL;
         end

         ST_SCRL: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff;
            if (cnt_ff < CELL_W'(CELLS - COLS)) begin
               ram_wr.data = {text_color_ff, ram_rd_data[CHAR_W-1:0]};
            end else begin
               ram_wr.data = {text_color_ff, BLANK_CHAR};
            end
            if (scrl_rd_next < (CELL_W+1)'(CELLS)) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = scrl_rd_next[CELL_W-1:0];
            end
            if (cnt_ff == CELL_W'(CELLS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff;
            ram_wr.data = {fill_color_ff, BLANK_CHAR};
            if (cnt_ff == CELL_W'(CELLS - 1)) begin
               // the pass after reset has no request behind it
               state_in = init_ff ? ST_IDLE : ST_FINISH;
               init_in  = 1'b0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = cur_row_ff;
               rsp_col_in   = cur_col_ff;
               rsp_off_in   = u_out[OFF_W-1:0];
               rsp_char_in  = rdchar_ff;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         fill_color_ff <= RESET_COLOR;
         init_ff       <= 1'b1;
         text_color_ff <= RESET_COLOR;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         fill_color_ff <= fill_color_in;
         init_ff       <= init_in;
         text_color_ff <= text_color_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_mode_ff  <= op_mode_in;
      op_char_ff  <= op_char_in;
      op_row_ff   <= op_row_in;
      op_col_ff   <= op_col_in;
      op_color_ff <= op_color_in;
      bad_ff      <= bad_in;
      rdchar_ff   <= rdchar_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_char_ff <= rsp_char_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

endmodule

// ===== rtl/core/tccw_screen_ram.sv =====
// screen cell memory, one write port and one registered read port
`timescale 1ns / 1ps

module tccw_screen_ram (
   input  logic                 clock,
   input  tccw_pkg::ram_wr_type wr,
   input  tccw_pkg::ram_rd_type rd,
   output tccw_pkg::cell_type   rd_data
);
   import tccw_pkg::*;

   cell_type mem [CELLS];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
